// ===== rtl/jac_pkg.sv =====
// jac_pkg: shared types, codes and reset constants for the J1939 address
// claim controller. No dependencies.
package jac_pkg;

    // Field widths fixed by the frame format
    localparam int unsigned NAME_W  = 64;
    localparam int unsigned ADDR_FW = 8;
    localparam int unsigned TMR_W   = 16;

    // Default size of the address space and the null address
    localparam int unsigned         NUM_ADDR_DEF = 254;
    localparam logic [ADDR_FW-1:0]  ADDR_NONE    = 8'd254;

    // Register reset values
    localparam logic [NAME_W-1:0]  OWN_NAME_RST      = 64'd0;
    localparam logic [ADDR_FW-1:0] POOL_FIRST_RST    = 8'd128;
    localparam logic [ADDR_FW-1:0] POOL_LAST_RST     = 8'd247;
    localparam logic [TMR_W-1:0]   CLAIM_TIMEOUT_RST = 16'd250;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OWN_NAME      = 2'd0,
        CFG_POOL_FIRST    = 2'd1,
        CFG_POOL_LAST     = 2'd2,
        CFG_CLAIM_TIMEOUT = 2'd3
    } cfg_idx_t;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CLAIM  = 2'd1,
        OP_TICK   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    // Claim state as reported
    typedef enum logic [1:0] {
        CS_INITIAL     = 2'd0,
        CS_CLAIMING    = 2'd1,
        CS_OPERATIONAL = 2'd2,
        CS_INVALID     = 2'd3
    } claim_state_t;

    // Sequencer states
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_STORE,
        SQ_SCAN,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic [NAME_W-1:0]  own_name;
        logic [ADDR_FW-1:0] pool_first;
        logic [ADDR_FW-1:0] pool_last;
        logic [TMR_W-1:0]   claim_timeout;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_FW-1:0] src_addr;
        logic [NAME_W-1:0]  claim_name;
    } item_t;

    typedef struct packed {
        claim_state_t       claim_state;
        logic [ADDR_FW-1:0] own_address;
        logic               send_claim;
        logic [ADDR_FW-1:0] found_address;
    } result_t;

    // Sequencer to NAME store
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_FW-1:0] wr_addr;
        logic [ADDR_FW-1:0] rd_addr;
    } store_cmd_t;

    // Shared compare unit flags
    typedef struct packed {
        logic eq;
        logic lt;
        logic a_zero;
    } cmp_res_t;

endpackage

// ===== rtl/jac_name_store.sv =====
// jac_name_store: per-address NAME memory, one write and one registered read
// port, with a valid bit per entry so that unwritten entries read as zero.
// Depends on jac_pkg.
module jac_name_store #(
    parameter int unsigned NUM_ADDR = jac_pkg::NUM_ADDR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jac_pkg::store_cmd_t          cmd,
    input  logic [jac_pkg::NAME_W-1:0]   wr_data,
    output logic [jac_pkg::NAME_W-1:0]   rd_data
);
    import jac_pkg::*;

    localparam int unsigned ADDR_W = $clog2(NUM_ADDR);

    logic [NAME_W-1:0]   mem [NUM_ADDR];
    logic [NUM_ADDR-1:0] valid_reg;
    logic [NAME_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;

    // Storage write
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr[ADDR_W-1:0]] <= wr_data;
        end
    end

    // Valid bits: cleared together at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.wr_en) begin
            valid_reg[cmd.wr_addr[ADDR_W-1:0]] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[cmd.rd_addr[ADDR_W-1:0]];
        rd_valid_reg <= (cmd.rd_addr < ADDR_FW'(NUM_ADDR))
                        && valid_reg[cmd.rd_addr[ADDR_W-1:0]];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/jac_cmp.sv =====
// jac_cmp: shared 64-bit magnitude compare unit used by the decode,
// store and scan steps of the sequencer. Depends on jac_pkg.
module jac_cmp (
    input  logic [jac_pkg::NAME_W-1:0] a,
    input  logic [jac_pkg::NAME_W-1:0] b,
    output jac_pkg::cmp_res_t          res
);
    import jac_pkg::*;

    // a against b, plus zero test of a
    always_comb begin
        res.eq     = (a == b);
        res.lt     = (a < b);
        res.a_zero = (a == '0);
    end

endmodule

// ===== rtl/jac_seq.sv =====
// jac_seq: sequencer for the address claim controller; holds claim state,
// own address and timer, steps the NAME store and the compare unit, and
// owns the result register. Depends on jac_pkg.
module jac_seq #(
    parameter int unsigned NUM_ADDR = jac_pkg::NUM_ADDR_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  jac_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  jac_pkg::item_t              in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output jac_pkg::result_t            out_result,
    output jac_pkg::store_cmd_t         st_cmd,
    output logic [jac_pkg::NAME_W-1:0]  st_wr_data,
    input  logic [jac_pkg::NAME_W-1:0]  st_rd_data,
    output logic [jac_pkg::NAME_W-1:0]  cmp_a,
    output logic [jac_pkg::NAME_W-1:0]  cmp_b,
    input  jac_pkg::cmp_res_t           cmp_res
);
    import jac_pkg::*;

    localparam logic [ADDR_FW-1:0] NUM_ADDR_V = ADDR_FW'(NUM_ADDR);

    seq_state_t         state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ADDR_FW-1:0] src_reg, src_next;
    logic [NAME_W-1:0]  nm_reg, nm_next;
    claim_state_t       mode_reg, mode_next;
    logic [ADDR_FW-1:0] address_reg, address_next;
    logic [TMR_W-1:0]   timer_count_reg, timer_count_next;
    logic               timer_running_reg, timer_running_next;
    logic               claim_after_reg, claim_after_next;
    logic               send_reg, send_next;
    logic [ADDR_FW-1:0] found_reg, found_next;
    logic [ADDR_FW-1:0] issue_idx_reg, issue_idx_next;
    logic [ADDR_FW-1:0] cand_idx_reg, cand_idx_next;
    logic               cand_vld_reg, cand_vld_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_result_reg, out_result_next;

    logic [TMR_W-1:0]   tick_count;
    logic               nm_above_own;
    logic               in_pool;
    logic               hit;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= SQ_IDLE;
            mode_reg          <= CS_INITIAL;
            address_reg       <= ADDR_NONE;
            timer_count_reg   <= '0;
            timer_running_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            cand_vld_reg      <= 1'b0;
        end else begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            address_reg       <= address_next;
            timer_count_reg   <= timer_count_next;
            timer_running_reg <= timer_running_next;
            out_valid_reg     <= out_valid_next;
            cand_vld_reg      <= cand_vld_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        src_reg         <= src_next;
        nm_reg          <= nm_next;
        claim_after_reg <= claim_after_next;
        send_reg        <= send_next;
        found_reg       <= found_next;
        issue_idx_reg   <= issue_idx_next;
        cand_idx_reg    <= cand_idx_next;
        out_result_reg  <= out_result_next;
    end

    // Shared compare operands
    always_comb begin
        cmp_a = (state_reg == SQ_DECODE) ? nm_reg : st_rd_data;
        if ((state_reg == SQ_SCAN && op_reg == OP_LOOKUP)
            || (state_reg == SQ_STORE && op_reg == OP_CLAIM)) begin
            cmp_b = nm_reg;
        end else begin
            cmp_b = cfg.own_name;
        end
    end

    assign tick_count   = TMR_W'(timer_count_reg + 1'b1);
    assign nm_above_own = !cmp_res.lt && !cmp_res.eq;
    assign in_pool      = (cand_idx_reg >= cfg.pool_first)
                          && (cand_idx_reg <= cfg.pool_last);

    // Scan hit for the entry whose data is on the read port
    always_comb begin
        if (op_reg == OP_LOOKUP) begin
            hit = cand_vld_reg && cmp_res.eq;
        end else begin
            hit = cand_vld_reg && in_pool && (cand_idx_reg != address_reg)
                  && (cmp_res.a_zero || !cmp_res.lt);
        end
    end

    // Next state and outputs
    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        src_next           = src_reg;
        nm_next            = nm_reg;
        mode_next          = mode_reg;
        address_next       = address_reg;
        timer_count_next   = timer_count_reg;
        timer_running_next = timer_running_reg;
        claim_after_next   = claim_after_reg;
        send_next          = send_reg;
        found_next         = found_reg;
        issue_idx_next     = issue_idx_reg;
        cand_idx_next      = cand_idx_reg;
        cand_vld_next      = cand_vld_reg;
        out_result_next    = out_result_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        in_ready           = 1'b0;
        st_cmd.wr_en       = 1'b0;
        st_cmd.wr_addr     = (op_reg == OP_TICK) ? address_reg : src_reg;
        st_cmd.rd_addr     = (op_reg == OP_TICK) ? address_reg : src_reg;
        st_wr_data         = cmp_b;

        case (state_reg)
            SQ_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next    = in_item.op;
                    src_next   = in_item.src_addr;
                    nm_next    = in_item.claim_name;
                    send_next  = 1'b0;
                    found_next = ADDR_NONE;
                    state_next = SQ_DECODE;
                end
            end

            SQ_DECODE: begin
                // read of the target entry is issued here for the store step
                case (op_reg)
                    OP_START, OP_LOOKUP: begin
                        issue_idx_next = '0;
                        cand_vld_next  = 1'b0;
                        state_next     = SQ_SCAN;
                    end
                    OP_CLAIM: begin
                        claim_after_next = 1'b0;
                        if (src_reg >= ADDR_NONE || src_reg >= NUM_ADDR_V || cmp_res.eq) begin
                            state_next = SQ_DONE;
                        end else if (src_reg != address_reg) begin
                            state_next = SQ_STORE;
                        end else if (mode_reg == CS_CLAIMING) begin
                            if (nm_above_own) begin
                                state_next = SQ_DONE;
                            end else begin
                                claim_after_next = 1'b1;
                                state_next       = SQ_STORE;
                            end
                        end else if (mode_reg == CS_OPERATIONAL) begin
                            if (nm_above_own) begin
                                send_next  = 1'b1;
                                state_next = SQ_DONE;
                            end else begin
                                claim_after_next = 1'b1;
                                state_next       = SQ_STORE;
                            end
                        end else begin
                            state_next = SQ_DONE;
                        end
                    end
                    OP_TICK: begin
                        claim_after_next = 1'b0;
                        state_next       = SQ_DONE;
                        if (timer_running_reg) begin
                            if (tick_count >= cfg.claim_timeout) begin
                                timer_running_next = 1'b0;
                                timer_count_next   = '0;
                                mode_next          = CS_OPERATIONAL;
                                state_next         = SQ_STORE;
                            end else begin
                                timer_count_next = tick_count;
                            end
                        end
                    end
                    default: begin
                        state_next = SQ_DONE;
                    end
                endcase
            end

            SQ_STORE: begin
                // keep the larger NAME
                st_cmd.wr_en = cmp_res.lt;
                if (claim_after_reg) begin
                    issue_idx_next = '0;
                    cand_vld_next  = 1'b0;
                    state_next     = SQ_SCAN;
                end else begin
                    state_next = SQ_DONE;
                end
            end

            SQ_SCAN: begin
                st_cmd.rd_addr = issue_idx_reg;
                if (hit || (!cand_vld_reg && issue_idx_reg >= NUM_ADDR_V)) begin
                    cand_vld_next = 1'b0;
                    state_next    = SQ_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        found_next = hit ? cand_idx_reg : ADDR_NONE;
                    end else begin
                        timer_count_next = '0;
                        if (hit) begin
                            address_next       = cand_idx_reg;
                            mode_next          = CS_CLAIMING;
                            timer_running_next = 1'b1;
                            send_next          = 1'b1;
                        end else begin
                            address_next       = ADDR_NONE;
                            mode_next          = CS_INVALID;
                            timer_running_next = 1'b0;
                            send_next          = 1'b0;
                        end
                    end
                end else if (issue_idx_reg < NUM_ADDR_V) begin
                    cand_idx_next  = issue_idx_reg;
                    cand_vld_next  = 1'b1;
                    issue_idx_next = ADDR_FW'(issue_idx_reg + 1'b1);
                end else begin
                    cand_vld_next = 1'b0;
                end
            end

            SQ_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next                = 1'b1;
                    out_result_next.claim_state   = mode_reg;
                    out_result_next.own_address   = address_reg;
                    out_result_next.send_claim    = send_reg;
                    out_result_next.found_address = found_reg;
                    state_next                    = SQ_IDLE;
                end
            end

            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

// ===== rtl/j1939_address_claim_controller.sv =====
// J1939 address claim controller, top level: configuration registers, stream packing,
// sequencer, compare unit and NAME store. Depends on jac_pkg and the jac_* modules.
// Claim and tick beats pass decode and, where needed, store; start and lookup beats
// scan the store, and lost contention stores then scans, one store entry per cycle.
// One beat in flight; the next beat is taken in the cycle after the result.
// Reset (synchronous, aresetn low): defaults, state initial, no address, store reads zero.
module j1939_address_claim_controller #(
    parameter int unsigned NUM_ADDR = jac_pkg::NUM_ADDR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [7:0] src_addr, [71:8] claim_name
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] claim_state, [9:2] own_address,
                                   // [10] send_claim, [18:11] found_address
);
    import jac_pkg::*;

    cfg_t       cfg_reg;
    item_t      in_item;
    result_t    out_result;
    store_cmd_t st_cmd;
    logic [NAME_W-1:0] st_wr_data;
    logic [NAME_W-1:0] st_rd_data;
    logic [NAME_W-1:0] cmp_a;
    logic [NAME_W-1:0] cmp_b;
    cmp_res_t   cmp_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_name      <= OWN_NAME_RST;
            cfg_reg.pool_first    <= POOL_FIRST_RST;
            cfg_reg.pool_last     <= POOL_LAST_RST;
            cfg_reg.claim_timeout <= CLAIM_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_OWN_NAME:      cfg_reg.own_name      <= cfg_wdata;
                CFG_POOL_FIRST:    cfg_reg.pool_first    <= cfg_wdata[7:0];
                CFG_POOL_LAST:     cfg_reg.pool_last     <= cfg_wdata[7:0];
                CFG_CLAIM_TIMEOUT: cfg_reg.claim_timeout <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Beat unpacking and packing
    assign in_item.op         = op_t'(s_tuser);
    assign in_item.src_addr   = s_tdata[7:0];
    assign in_item.claim_name = s_tdata[71:8];

    assign m_tdata = {5'd0, out_result.found_address, out_result.send_claim,
                      out_result.own_address, out_result.claim_state};

    jac_seq #(
        .NUM_ADDR (NUM_ADDR)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .st_cmd     (st_cmd),
        .st_wr_data (st_wr_data),
        .st_rd_data (st_rd_data),
        .cmp_a      (cmp_a),
        .cmp_b      (cmp_b),
        .cmp_res    (cmp_res)
    );

    jac_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    jac_name_store #(
        .NUM_ADDR (NUM_ADDR)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (st_cmd),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

endmodule

// ===== sim/j1939_address_claim_controller_test.sv =====
// Self-checking testbench for j1939_address_claim_controller: stream driver,
// result monitor and a cycle-free predictor of the address claim behaviour.
// Depends on rtl/jac_pkg.sv and rtl/j1939_address_claim_controller.sv.
`timescale 1ns / 100ps

module j1939_address_claim_controller_test;
    import jac_pkg::*;

    localparam int unsigned NUM_ADDR   = NUM_ADDR_DEF;
    // longest scan of the NAME store plus margin
    localparam int unsigned SETTLE_CYC = NUM_ADDR + 16;
    localparam int unsigned QUIET_MAX  = 4000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;   // [7:0] src_addr, [71:8] claim_name
    logic [1:0]  s_tuser   = '0;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [1:0] claim_state, [9:2] own_address,
                                   // [10] send_claim, [18:11] found_address

    j1939_address_claim_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state: configuration copy and controller state
    logic [63:0]  cfg_own     = OWN_NAME_RST;
    logic [7:0]   cfg_first   = POOL_FIRST_RST;
    logic [7:0]   cfg_last    = POOL_LAST_RST;
    logic [15:0]  cfg_timeout = CLAIM_TIMEOUT_RST;
    logic [63:0]  name_tab [NUM_ADDR];
    claim_state_t claim_mode  = CS_INITIAL;
    logic [7:0]   hold_addr   = ADDR_NONE;
    logic [15:0]  tick_count  = '0;
    bit           timer_on    = 1'b0;

    item_t        events_pending [$];
    result_t      status_due [$];
    logic [63:0]  recent_names [$];
    item_t        cur_event;
    int unsigned  idle_pct   = 0;
    bit           calm       = 1'b0;
    int unsigned  fail_count = 0;
    int unsigned  quiet_cyc  = 0;

    initial begin
        for (int a = 0; a < NUM_ADDR; a++) name_tab[a] = '0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // NAME store keeps the larger NAME per address
    function automatic void keep_larger(logic [7:0] a, logic [63:0] nm);
        if (a < NUM_ADDR && name_tab[a] < nm) name_tab[a] = nm;
    endfunction

    // First pool address that is free or held by a NAME not below ours
    function automatic logic [7:0] pick_free_address();
        for (int a = 0; a < NUM_ADDR; a++) begin
            if (a < cfg_first || a > cfg_last || a == hold_addr) continue;
            if (name_tab[a] == '0 || name_tab[a] >= cfg_own) return a[7:0];
        end
        return ADDR_NONE;
    endfunction

    function automatic bit claim_fresh();
        hold_addr  = pick_free_address();
        tick_count = '0;
        if (hold_addr == ADDR_NONE) begin
            claim_mode = CS_INVALID;
            timer_on   = 1'b0;
            return 1'b0;
        end
        claim_mode = CS_CLAIMING;
        timer_on   = 1'b1;
        return 1'b1;
    endfunction

    // Advance the controller by one event and return the status it reports
    function automatic result_t advance_controller(item_t ev);
        result_t    r;
        bit         send;
        logic [7:0] found;
        send  = 1'b0;
        found = ADDR_NONE;
        case (ev.op)
            OP_START: begin
                send = claim_fresh();
            end
            OP_CLAIM: begin
                if (ev.src_addr < NUM_ADDR && ev.src_addr < ADDR_NONE
                        && ev.claim_name != cfg_own) begin
                    if (ev.src_addr != hold_addr) begin
                        keep_larger(ev.src_addr, ev.claim_name);
                    end else if (claim_mode == CS_CLAIMING) begin
                        if (ev.claim_name < cfg_own) begin
                            keep_larger(ev.src_addr, ev.claim_name);
                            send = claim_fresh();
                        end
                    end else if (claim_mode == CS_OPERATIONAL) begin
                        if (ev.claim_name > cfg_own) begin
                            send = 1'b1;
                        end else begin
                            keep_larger(ev.src_addr, ev.claim_name);
                            send = claim_fresh();
                        end
                    end
                end
            end
            OP_TICK: begin
                if (timer_on) begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count >= cfg_timeout) begin
                        timer_on   = 1'b0;
                        tick_count = '0;
                        claim_mode = CS_OPERATIONAL;
                        keep_larger(hold_addr, cfg_own);
                    end
                end
            end
            default: begin
                for (int a = 0; a < NUM_ADDR; a++) begin
                    if (found == ADDR_NONE && name_tab[a] == ev.claim_name) found = a[7:0];
                end
            end
        endcase
        r.claim_state   = claim_mode;
        r.own_address   = hold_addr;
        r.send_claim    = send;
        r.found_address = found;
        return r;
    endfunction

    // Random event, biased towards contention on the address now held
    function automatic item_t make_random_event();
        item_t       ev;
        int unsigned pick;
        logic [63:0] below;
        logic [63:0] above;
        below = (cfg_own == '0) ? '0 : rand64() % cfg_own;
        above = (&cfg_own) ? cfg_own : cfg_own + 64'd1 + rand64() % ~cfg_own;
        ev.op         = OP_TICK;
        ev.src_addr   = hold_addr;
        ev.claim_name = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            ev.op = OP_START;
        end else if (pick < 44) begin
            ev.op = OP_TICK;
        end else if (pick < 54) begin
            ev.op         = OP_CLAIM;
            ev.claim_name = below;
        end else if (pick < 60) begin
            ev.op         = OP_CLAIM;
            ev.claim_name = above;
        end else if (pick < 70) begin
            // another node takes a pool address
            ev.op         = OP_CLAIM;
            ev.src_addr   = cfg_first + 8'($urandom_range(0, 7));
            ev.claim_name = $urandom_range(0, 1) ? below : ev.claim_name;
        end else if (pick < 73) begin
            ev.op         = OP_CLAIM;
            ev.claim_name = cfg_own;
        end else if (pick < 86) begin
            ev.op = OP_LOOKUP;
            case ($urandom_range(0, 3))
                0: ev.claim_name = cfg_own;
                1: ev.claim_name = '0;
                2: if (recent_names.size() != 0)
                       ev.claim_name = recent_names[$urandom_range(0, recent_names.size() - 1)];
                default: ;
            endcase
        end else begin
            ev.op       = op_t'($urandom_range(0, 3));
            ev.src_addr = 8'($urandom_range(0, 255));
        end
        if (ev.op == OP_CLAIM) begin
            recent_names.push_back(ev.claim_name);
            if (recent_names.size() > 32) void'(recent_names.pop_front());
        end
        return ev;
    endfunction

    // Driver: one event per beat, idle bursts between beats only
    always @(posedge aclk) begin : drive
        logic        nxt_valid;
        int unsigned gap_left;
        if (!aresetn) begin
            gap_left = 0;
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                status_due.push_back(advance_controller(cur_event));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (events_pending.size() != 0) begin
                    if (!calm && $urandom_range(0, 99) < idle_pct) begin
                        gap_left = $urandom_range(1, 13) - 1;
                    end else begin
                        cur_event = events_pending.pop_front();
                        nxt_valid = 1'b1;
                        s_tdata <= {cur_event.claim_name, cur_event.src_addr};
                        s_tuser <= cur_event.op;
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // Monitor: compare each status beat with the oldest prediction
    always @(posedge aclk) begin : monitor
        result_t     want;
        int unsigned stall_left;
        if (!aresetn) begin
            stall_left = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    $error("status beat with no prediction pending: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    if (m_tdata[1:0] !== want.claim_state) begin
                        $error("claim_state: expected %0d, got %0d",
                               want.claim_state, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[9:2] !== want.own_address) begin
                        $error("own_address: expected %0d, got %0d",
                               want.own_address, m_tdata[9:2]);
                        fail_count++;
                    end
                    if (m_tdata[10] !== want.send_claim) begin
                        $error("send_claim: expected %0d, got %0d",
                               want.send_claim, m_tdata[10]);
                        fail_count++;
                    end
                    if (m_tdata[18:11] !== want.found_address) begin
                        $error("found_address: expected %0d, got %0d",
                               want.found_address, m_tdata[18:11]);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cyc <= 0;
        else quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= QUIET_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Wait until nothing is in flight, then let the longest scan pass
    task automatic settle();
        do @(negedge aclk);
        while (events_pending.size() != 0 || s_tvalid || status_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic set_registers(logic [63:0] own, logic [7:0] first,
                                 logic [7:0] last, logic [15:0] tmo);
        settle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_OWN_NAME;
        cfg_wdata <= own;
        @(posedge aclk);
        cfg_addr  <= CFG_POOL_FIRST;
        cfg_wdata <= {56'd0, first};
        @(posedge aclk);
        cfg_addr  <= CFG_POOL_LAST;
        cfg_wdata <= {56'd0, last};
        @(posedge aclk);
        cfg_addr  <= CFG_CLAIM_TIMEOUT;
        cfg_wdata <= {48'd0, tmo};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_own     = own;
        cfg_first   = first;
        cfg_last    = last;
        cfg_timeout = tmo;
    endtask

    // Events are issued one at a time so generation sees the settled state
    task automatic next_slot();
        do @(negedge aclk);
        while (events_pending.size() != 0 || s_tvalid);
    endtask

    task automatic queue_event(op_t op, logic [7:0] src, logic [63:0] nm);
        item_t ev;
        next_slot();
        ev.op         = op;
        ev.src_addr   = src;
        ev.claim_name = nm;
        events_pending.push_back(ev);
    endtask

    // Stimulus
    initial begin
        logic [7:0] first;
        item_t      ev;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        idle_pct = 20;

        // Reset defaults: empty store, ignored sources, restart skips held address
        queue_event(OP_LOOKUP, 8'd0,   64'd0);
        queue_event(OP_TICK,   8'd0,   64'd0);
        queue_event(OP_CLAIM,  8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(OP_CLAIM,  8'd254, 64'd1);
        queue_event(OP_CLAIM,  8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(OP_CLAIM,  8'd0,   64'd5);
        queue_event(OP_LOOKUP, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(OP_START,  8'd0,   64'd0);
        queue_event(OP_CLAIM,  8'd128, 64'd5);
        queue_event(OP_CLAIM,  8'd128, 64'd0);
        queue_event(OP_START,  8'd0,   64'd0);
        queue_event(OP_LOOKUP, 8'd0,   64'd0);

        // Top of the address range, zero timeout, defend then lose everything
        set_registers(64'h8000_0000_0000_0000, 8'd250, 8'd253, 16'd0);
        queue_event(OP_START,  8'd0,   64'd0);
        queue_event(OP_TICK,   8'd0,   64'd0);
        queue_event(OP_CLAIM,  8'd250, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_event(OP_CLAIM,  8'd250, 64'd1);
        queue_event(OP_CLAIM,  8'd252, 64'd1);
        queue_event(OP_CLAIM,  8'd253, 64'd2);
        queue_event(OP_TICK,   8'd0,   64'd0);
        queue_event(OP_CLAIM,  8'd251, 64'd3);
        queue_event(OP_TICK,   8'd0,   64'd0);
        queue_event(OP_LOOKUP, 8'd0,   64'h8000_0000_0000_0000);
        queue_event(OP_START,  8'd0,   64'd0);

        // Reversed pool bounds leave no address at all
        set_registers(64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 8'd5, 16'hFFFF);
        queue_event(OP_START,  8'd0,   64'd0);

        // Random phases; each one starts only once all statuses are back
        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: set_registers(rand64(), 8'd0, 8'd253, 16'd3);
                1: set_registers(64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd255, 16'd1);
                2: set_registers(64'd1, 8'd253, 8'd253, 16'd0);
                3: set_registers(rand64(), 8'd200, 8'd100, 16'd2);
                4: set_registers(rand64(), 8'd240, 8'd255, 16'hFFFF);
                default: begin
                    first = 8'($urandom_range(0, 253));
                    set_registers(rand64(), first, first + 8'($urandom_range(0, 6)),
                                  16'($urandom_range(0, 12)));
                end
            endcase
            @(negedge aclk);
            calm = (ph == 10);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            queue_event(OP_START, 8'd0, 64'd0);
            for (int n = 0; n < 102; n++) begin
                next_slot();
                ev = make_random_event();
                events_pending.push_back(ev);
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jac_pkg.sv
rtl/jac_name_store.sv
rtl/jac_cmp.sv
rtl/jac_seq.sv
rtl/j1939_address_claim_controller.sv
sim/j1939_address_claim_controller_test.sv
